### sv/mis_pkg.sv
package mis_pkg;

    // data path width of value, modulus and inverse
    localparam int WIDTH = 16;
    // bit counter for the remainder pass
    localparam int CNT_W = $clog2(WIDTH);

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_NONE = 2'd1,
        STATUS_ZERO = 2'd2
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic             load;
        logic             div_step;
        logic [CNT_W-1:0] div_bit;
        logic             srch_step;
        logic             finish;
        status_t          fin_status;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_zero;
        logic mod_small;
        logic hit;
        logic last_cand;
    } sts_t;

endpackage

### sv/mis_ctrl.sv
module mis_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output logic          done,
    input  mis_pkg::sts_t sts,
    output mis_pkg::cmd_t cmd
);
    import mis_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_SRCH
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        done_next      = 1'b0;
        cmd            = '0;
        cmd.fin_status = STATUS_OK;
        cmd.div_bit    = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cnt_next = CNT_W'(WIDTH - 1);
                if (sts.is_zero)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = STATUS_ZERO;
                    done_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (sts.mod_small)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = STATUS_NONE;
                    done_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH:
            begin
                if (sts.hit)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = STATUS_OK;
                    done_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (sts.last_cand)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = STATUS_NONE;
                    done_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cmd.srch_step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

    // strobe comes only right after a request was in work
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done strobe without a request in work");

    // no work commands while idle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !cmd.div_step && !cmd.srch_step && !cmd.finish)
        else $error("datapath command while idle");

    // search runs only after the full remainder pass
    a_srch_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRCH) && $past(state_reg == ST_DIV) |-> $past(cnt_reg == '0))
        else $error("search entered before remainder done");

endmodule

### sv/mis_dpath.sv
module mis_dpath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic [mis_pkg::WIDTH-1:0]  cfg_data,
    input  logic [mis_pkg::WIDTH-1:0]  value,
    input  mis_pkg::cmd_t              cmd,
    output mis_pkg::sts_t              sts,
    output logic [mis_pkg::WIDTH-1:0]  inverse,
    output mis_pkg::status_t           status
);
    import mis_pkg::*;

    logic [WIDTH-1:0] mod_reg;
    logic             neg_reg;
    logic             zero_reg;
    logic [WIDTH-1:0] mag_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] cand_reg;
    logic [WIDTH-1:0] inverse_reg;
    status_t          status_reg;

    logic [WIDTH:0]   shifted;
    logic [WIDTH-1:0] rem_next;
    logic [WIDTH-1:0] room;
    logic [WIDTH-1:0] acc_next;
    logic [WIDTH-1:0] inv_ok;

    // one restoring step of mag mod modulus
    always_comb
    begin
        shifted = {rem_reg, mag_reg[cmd.div_bit]};
        if (shifted >= {1'b0, mod_reg})
        begin
            rem_next = WIDTH'(shifted - {1'b0, mod_reg});
        end
        else
        begin
            rem_next = shifted[WIDTH-1:0];
        end
    end

    // running residue plus step, reduced without overflow
    always_comb
    begin
        room = mod_reg - rem_reg;
        if (acc_reg >= room)
        begin
            acc_next = acc_reg - room;
        end
        else
        begin
            acc_next = acc_reg + rem_reg;
        end
    end

    assign inv_ok = neg_reg ? (mod_reg - cand_reg) : cand_reg;

    assign sts.is_zero   = zero_reg;
    assign sts.mod_small = (mod_reg < WIDTH'(2));
    assign sts.hit       = (acc_next == WIDTH'(1));
    assign sts.last_cand = (cand_reg == (mod_reg - WIDTH'(1)));

    // modulus register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg <= WIDTH'(2);
        end
        else if (cfg_valid)
        begin
            mod_reg <= cfg_data;
        end
    end

    // request operands and search registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg  <= value[WIDTH-1];
            zero_reg <= (value == '0);
            mag_reg  <= value[WIDTH-1] ? (~value + WIDTH'(1)) : value;
            rem_reg  <= '0;
            acc_reg  <= '0;
            cand_reg <= WIDTH'(1);
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_next;
        end
        if (cmd.srch_step)
        begin
            acc_reg  <= acc_next;
            cand_reg <= cand_reg + WIDTH'(1);
        end
    end

    // result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inverse_reg <= '0;
            status_reg  <= STATUS_OK;
        end
        else if (cmd.finish)
        begin
            status_reg  <= cmd.fin_status;
            inverse_reg <= (cmd.fin_status == STATUS_OK) ? inv_ok : '0;
        end
    end

    assign inverse = inverse_reg;
    assign status  = status_reg;

    // residue stays reduced while searching
    a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.srch_step |-> (acc_reg < mod_reg) && (rem_reg < mod_reg))
        else $error("search residue not reduced");

    // candidate never reaches the modulus
    a_cand_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.srch_step |=> (cand_reg < mod_reg) && (cand_reg != '0))
        else $error("candidate out of range");

    // a found inverse is nonzero and below the modulus
    a_inv_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && (cmd.fin_status == STATUS_OK) |=>
            (inverse_reg != '0) && (inverse_reg < mod_reg))
        else $error("inverse out of range");

endmodule

### sv/modular_inverse_search.sv
// Modular inverse by linear search over multipliers 1 .. modulus-1.
// A zero value or a modulus below 2 finishes at the check after the accepting
// edge; else a bit-serial remainder pass runs, then k candidates are tried (k <= modulus-1).
// Rate: one request at a time; the remainder pass walks all 16 bits serially, then
// one candidate per cycle through the modular adder. busy is high meanwhile.
// Results show for one cycle on done; the receiver cannot stall. Reset sets modulus to 2.
module modular_inverse_search (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [mis_pkg::WIDTH-1:0]  value,
    output logic                       done,
    output logic [mis_pkg::WIDTH-1:0]  inverse,
    output logic [1:0]                 status,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [mis_pkg::WIDTH-1:0]  cfg_data
);
    import mis_pkg::*;

    cmd_t    cmd;
    sts_t    sts;
    status_t dp_status;

    assign cfg_ready = 1'b1;
    assign status    = dp_status;

    // sequencer
    mis_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .sts   (sts),
        .cmd   (cmd)
    );

    // arithmetic and result registers
    mis_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .value     (value),
        .cmd       (cmd),
        .sts       (sts),
        .inverse   (inverse),
        .status    (dp_status)
    );

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mis_pkg::*;

    localparam int          HALF_PERIOD = 6;
    localparam int          RESET_CYCLES = 8;
    localparam int          RANDOM_ITEMS = 70;
    localparam int          TAIL_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT = 4000000;

    // one entry of the stimulus list: a modulus write or a value to invert
    typedef struct packed {
        logic             is_cfg;
        logic [WIDTH-1:0] data;
    } job_t;

    typedef struct packed {
        logic [WIDTH-1:0] inverse;
        status_t          status;
    } inv_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic [WIDTH-1:0] value = '0;
    logic             cfg_valid = 1'b0;
    logic [WIDTH-1:0] cfg_data = '0;
    logic             busy;
    logic             done;
    logic [WIDTH-1:0] inverse;
    logic [1:0]       status;
    logic             cfg_ready;

    job_t             job_queue[$];
    inv_result_t      predicted_inverses[$];
    logic [WIDTH-1:0] ring_modulus = 16'd2;
    int               req_issued = 0;
    int               req_taken = 0;
    int               cfg_issued = 0;
    int               cfg_taken = 0;
    int               fail_count = 0;
    int               gap_left = 0;
    int               burst_left = 1;
    int unsigned      cycle_count = 0;

    modular_inverse_search uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .done      (done),
        .inverse   (inverse),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // linear search with a running residue, same order as the hardware
    function automatic inv_result_t search_inverse(input logic [WIDTH-1:0] v,
                                                   input logic [WIDTH-1:0] m);
        inv_result_t      r;
        logic             neg;
        logic [WIDTH-1:0] mag;
        logic [WIDTH:0]   acc;
        logic [WIDTH:0]   stride;
        int unsigned      k;
        logic             found;
        r.inverse = '0;
        r.status = STATUS_NONE;
        neg = v[WIDTH-1];
        mag = neg ? -v : v;
        found = 1'b0;
        if (v == '0)
        begin
            r.status = STATUS_ZERO;
        end
        else if (m >= 2)
        begin
            stride = {1'b0, mag % m};
            acc = '0;
            for (k = 1; k < m && !found; k++)
            begin
                acc = acc + stride;
                if (acc >= {1'b0, m})
                    acc = acc - {1'b0, m};
                if (acc == 1)
                begin
                    found = 1'b1;
                    r.inverse = neg ? m - k[WIDTH-1:0] : k[WIDTH-1:0];
                    r.status = STATUS_OK;
                end
            end
        end
        return r;
    endfunction

    task automatic add_item(input int v);
        job_t j;
        j.is_cfg = 1'b0;
        j.data = v[WIDTH-1:0];
        job_queue.push_back(j);
    endtask

    task automatic add_cfg(input int m);
        job_t j;
        j.is_cfg = 1'b1;
        j.data = m[WIDTH-1:0];
        job_queue.push_back(j);
    endtask

    // driver: one request or one modulus write at a time, bursts and gaps
    always @(negedge clk)
    begin : drive
        logic next_start;
        logic next_cfg;
        job_t j;
        next_start = start;
        next_cfg = cfg_valid;
        if (!rst_n)
        begin
            next_start = 1'b0;
            next_cfg = 1'b0;
        end
        else
        begin
            if (start && req_taken == req_issued)
                next_start = 1'b0;
            if (cfg_valid && cfg_taken == cfg_issued)
                next_cfg = 1'b0;
            if (!next_start && !next_cfg)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                end
                else if (job_queue.size() > 0)
                begin
                    j = job_queue[0];
                    if (j.is_cfg)
                    begin
                        // modulus changes only once every result is back
                        if (predicted_inverses.size() == 0)
                        begin
                            void'(job_queue.pop_front());
                            cfg_data <= j.data;
                            next_cfg = 1'b1;
                            cfg_issued = cfg_issued + 1;
                        end
                    end
                    else
                    begin
                        void'(job_queue.pop_front());
                        value <= j.data;
                        next_start = 1'b1;
                        req_issued = req_issued + 1;
                        burst_left = burst_left - 1;
                        if (burst_left <= 0)
                        begin
                            burst_left = $urandom_range(1, 8);
                            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                        end
                    end
                end
            end
        end
        start <= next_start;
        cfg_valid <= next_cfg;
    end

    // monitor: track accepted writes and requests, check every result
    always @(posedge clk)
    begin : monitor
        inv_result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                ring_modulus = cfg_data;
                cfg_taken = cfg_taken + 1;
            end
            if (start && !busy)
            begin
                predicted_inverses.push_back(search_inverse(value, ring_modulus));
                req_taken = req_taken + 1;
            end
            if (done)
            begin
                if (predicted_inverses.size() == 0)
                begin
                    $error("result with nothing pending: inverse %0d status %0d",
                           inverse, status);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = predicted_inverses.pop_front();
                    if (inverse !== want.inverse)
                    begin
                        $error("inverse: expected %0d, got %0d", want.inverse, inverse);
                        fail_count = fail_count + 1;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int n_rand;
        int pick;
        int m;
        int v;
        int kind;
        int count;

        // reset modulus 2: odd values invert to 1, even nonzero ones have none, zero is flagged
        add_item(0);
        add_item(1);
        add_item(-1);
        add_item(2);
        add_item(32767);
        add_item(-32768);
        // small prime, sign handling and shared factors
        add_cfg(7);
        add_item(0);
        add_item(3);
        add_item(-3);
        add_item(7);
        add_item(-7);
        add_item(6);
        add_item(-1);
        add_item(32767);
        // modulus zero and one never give a residue of one
        add_cfg(0);
        add_item(5);
        add_item(0);
        add_item(-32768);
        add_cfg(1);
        add_item(1);
        add_item(-1);
        // widest modulus: long searches and a full search with no hit
        add_cfg(65535);
        add_item(2);
        add_item(-2);
        add_item(3);
        add_item(-32768);
        add_cfg(65521);
        add_item($urandom_range(0, 65535));
        add_item($urandom_range(0, 65535));

        // random phases, mostly small moduli to keep searches short
        n_rand = 0;
        while (n_rand < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                m = $urandom_range(0, 1);
            else if (pick < 5)
                m = $urandom_range(2, 3000);
            else
                m = $urandom_range(2, 200);
            add_cfg(m);
            count = $urandom_range(4, 12);
            repeat (count)
            begin
                kind = $urandom_range(0, 7);
                if (kind == 0)
                    v = 0;
                else if (kind == 1)
                    v = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8)
                                                     : -$urandom_range(1, 8);
                else if (kind == 2)
                    v = ($urandom_range(0, 1) == 0) ? m * $urandom_range(1, 4)
                                                     : -(m * $urandom_range(1, 4));
                else
                    v = $urandom_range(0, 65535);
                add_item(v);
                n_rand = n_rand + 1;
            end
        end

        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (job_queue.size() > 0 || predicted_inverses.size() > 0 || start || cfg_valid)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && predicted_inverses.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
